### design/tccw_pkg.sv
package tccw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   localparam int CMD_W       = 2;
   localparam int CHAR_W      = 8;
   localparam int ROW_PORT_W  = 5;
   localparam int COL_PORT_W  = 7;
   localparam int ENTRY_W     = 16;
   localparam int ATTR_W      = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

   localparam int TAB_STEP = 4;

   typedef enum logic [2:0] {
      OP_CHAR,
      OP_NEWLINE,
      OP_TAB,
      OP_CLEAR,
      OP_READ,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [CHAR_W-1:0]      char_code;
      logic [ROW_PORT_W-1:0]  row;
      logic [COL_PORT_W-1:0]  col;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_READ,
      ST_BLANK,
      ST_FILL
   } state_type;

endpackage

### design/tccw_front.sv
module tccw_front
   import tccw_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  logic                   start,
   output logic                   busy,
   input  logic [CMD_W-1:0]       req_command,
   input  logic [CHAR_W-1:0]      req_char_code,
   input  logic [ROW_PORT_W-1:0]  req_cell_row,
   input  logic [COL_PORT_W-1:0]  req_cell_col,
   input  queue_status_type       q_status,
   output logic                   push,
   output item_type               item
);

   logic in_range;

   assign busy     = q_status.full;
   assign push     = start && !q_status.full;
   assign in_range = (int'(req_cell_row) < ROWS) && (int'(req_cell_col) < COLUMNS);

   always_comb begin
      item.char_code = req_char_code;
      item.row       = req_cell_row;
      item.col       = req_cell_col;
      item.op        = OP_NOP;
      unique case (req_command)
         CMD_PUT: begin
            if (req_char_code == CH_NEWLINE) begin
               item.op = OP_NEWLINE;
            end else if (req_char_code == CH_TAB) begin
               item.op = OP_TAB;
            end else begin
               item.op = OP_CHAR;
            end
         end
         CMD_CLEAR: begin
            item.op = OP_CLEAR;
         end
         CMD_READ: begin
            item.op = in_range ? OP_READ : OP_NOP;
         end
         default: begin
            item.op = OP_NOP;
         end
      endcase
   end

endmodule

### design/tccw_queue.sv
module tccw_queue
   import tccw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head,
   output queue_status_type q_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head           = entries_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/tccw_back.sv
module tccw_back
   import tccw_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  queue_status_type       q_status,
   input  item_type               head,
   output logic                   pop,
   input  logic                   csr_valid,
   input  logic [ATTR_W-1:0]      csr_text_attribute,
   output logic                   rsp_strobe,
   output logic [ROW_PORT_W-1:0]  rsp_cursor_row,
   output logic [COL_PORT_W-1:0]  rsp_cursor_col,
   output logic [ENTRY_W-1:0]     rsp_read_entry,
   output logic                   rsp_scrolled
);

   localparam int DEPTH  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RW     = $clog2(ROWS);
   localparam int RW1    = RW + 1;
   localparam int CW     = $clog2(COLUMNS);
   localparam int CW1    = CW + 1;

   state_type           state_ff, state_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       base_ff, base_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;
   logic [ADDR_W-1:0]   blank_base_ff, blank_base_in;
   logic [ATTR_W-1:0]   attr_ff;

   logic [ENTRY_W-1:0]  cell_mem [DEPTH];
   logic [ENTRY_W-1:0]  rd_data_ff;

   logic                rsp_strobe_ff;
   logic [ROW_PORT_W-1:0] rsp_row_ff;
   logic [COL_PORT_W-1:0] rsp_col_ff;
   logic [ENTRY_W-1:0]  rsp_entry_ff;
   logic                rsp_scrolled_ff;

   logic                active;
   logic [CW1-1:0]      col_wide;
   logic [CW1-1:0]      col_next_w;
   logic                col_over;
   logic                line_adv;
   logic                at_bottom;
   logic                do_scroll;
   logic [RW-1:0]       base_inc;
   logic [RW-1:0]       sel_row;
   logic [CW-1:0]       sel_col;
   logic [RW1-1:0]      phys_w;
   logic [RW-1:0]       phys_row;
   logic [ADDR_W-1:0]   cur_addr;
   logic                sweep_last_col;
   logic                sweep_last_cell;

   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0]  mem_wdata;
   logic                mem_re;
   logic                emit;
   logic [ENTRY_W-1:0]  emit_entry;
   logic                emit_scrolled;

   // shared decode of the item at the head of the queue
   always_comb begin
      active   = (state_ff == ST_RUN) && !q_status.empty;
      col_wide = {1'b0, col_ff};
      case (head.op)
         OP_CHAR: col_next_w = col_wide + CW1'(1);
         OP_TAB:  col_next_w = (col_wide + CW1'(TAB_STEP)) & ~CW1'(TAB_STEP - 1);
         default: col_next_w = col_wide;
      endcase
      col_over  = (col_next_w >= CW1'(COLUMNS));
      line_adv  = active && ((head.op == OP_NEWLINE) ||
                             (((head.op == OP_CHAR) || (head.op == OP_TAB)) && col_over));
      at_bottom = (row_ff == RW'(ROWS - 1));
      do_scroll = line_adv && at_bottom;
      base_inc  = (base_ff == RW'(ROWS - 1)) ? '0 : base_ff + 1'b1;

      sel_row  = (head.op == OP_READ) ? RW'(head.row) : row_ff;
      sel_col  = (head.op == OP_READ) ? CW'(head.col) : col_ff;
      phys_w   = {1'b0, sel_row} + {1'b0, base_ff};
      phys_row = (phys_w >= RW1'(ROWS)) ? RW'(phys_w - RW1'(ROWS)) : RW'(phys_w);
      cur_addr = ADDR_W'(32'(phys_row) * COLUMNS + 32'(sel_col));

      sweep_last_col  = (sweep_ff == ADDR_W'(COLUMNS - 1));
      sweep_last_cell = (sweep_ff == ADDR_W'(DEPTH - 1));
   end

   // next state
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      base_in       = base_ff;
      sweep_in      = sweep_ff;
      blank_base_in = blank_base_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (active) begin
               case (head.op) inside
                  OP_CLEAR: begin
                     state_in = ST_FILL;
                     row_in   = '0;
                     col_in   = '0;
                     base_in  = '0;
                     sweep_in = '0;
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
                  OP_CHAR, OP_TAB, OP_NEWLINE: begin
                     if (line_adv) begin
                        col_in = '0;
                        if (at_bottom) begin
                           base_in       = base_inc;
                           blank_base_in = ADDR_W'(32'(base_ff) * COLUMNS);
                           sweep_in      = '0;
                           state_in      = ST_BLANK;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end else begin
                        col_in = CW'(col_next_w);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_RUN;
         end
         ST_BLANK: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last_col) begin
               state_in = ST_RUN;
            end
         end
         ST_FILL: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last_cell) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // outputs
   always_comb begin
      pop           = active;
      mem_we        = 1'b0;
      mem_waddr     = cur_addr;
      mem_wdata     = {attr_ff, head.char_code};
      mem_re        = 1'b0;
      emit          = 1'b0;
      emit_entry    = '0;
      emit_scrolled = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (active) begin
               case (head.op) inside
                  OP_CHAR: begin
                     mem_we = 1'b1;
                     emit   = !do_scroll;
                  end
                  OP_TAB, OP_NEWLINE: begin
                     emit = !do_scroll;
                  end
                  OP_READ: begin
                     mem_re = 1'b1;
                  end
                  OP_CLEAR: begin
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            emit       = 1'b1;
            emit_entry = rd_data_ff;
         end
         ST_BLANK: begin
            mem_we        = 1'b1;
            mem_waddr     = blank_base_ff + sweep_ff;
            mem_wdata     = {attr_ff, CH_SPACE};
            emit          = sweep_last_col;
            emit_scrolled = sweep_last_col;
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = {attr_ff, CH_SPACE};
            emit      = sweep_last_cell;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         row_ff        <= '0;
         col_ff        <= '0;
         base_ff       <= '0;
         sweep_ff      <= '0;
         blank_base_ff <= '0;
         attr_ff       <= ATTR_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         base_ff       <= base_in;
         sweep_ff      <= sweep_in;
         blank_base_ff <= blank_base_in;
         rsp_strobe_ff <= emit;
         if (csr_valid) begin
            attr_ff <= csr_text_attribute;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_row_ff      <= ROW_PORT_W'(row_in);
         rsp_col_ff      <= COL_PORT_W'(col_in);
         rsp_entry_ff    <= emit_entry;
         rsp_scrolled_ff <= emit_scrolled;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cell_mem[cur_addr];
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_read_entry = rsp_entry_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

endmodule

### design/text_console_cell_writer.sv
// Channel    Ports                                          Handshake
// command    start, busy, req_command .. req_cell_col       beat when start & !busy
// result     rsp_strobe, rsp_cursor_*, rsp_read_entry, ...  one cycle, no back-pressure
// attribute  csr_valid, csr_ready, csr_text_attribute       beat when valid & ready
//
// Put, newline and tab: queued, popped and answered with a registered result strobe, one
// per cycle while no read, scroll or clear is in progress. Read: one cell memory read port
// with registered data. Scroll: blanks the new bottom line one cell a cycle; rows rotate
// through a base-row offset, so nothing is copied. Clear: blanks every cell in turn.
// A 2-entry command queue absorbs beats during scroll and clear; busy rises when it fills.
// Reset is synchronous; cell memory is not cleared and holds garbage until written.
module text_console_cell_writer
   import tccw_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [CMD_W-1:0]       req_command,
   input  logic [CHAR_W-1:0]      req_char_code,
   input  logic [ROW_PORT_W-1:0]  req_cell_row,
   input  logic [COL_PORT_W-1:0]  req_cell_col,
   output logic                   rsp_strobe,
   output logic [ROW_PORT_W-1:0]  rsp_cursor_row,
   output logic [COL_PORT_W-1:0]  rsp_cursor_col,
   output logic [ENTRY_W-1:0]     rsp_read_entry,
   output logic                   rsp_scrolled,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [ATTR_W-1:0]      csr_text_attribute
);

   queue_status_type q_status;
   item_type         push_item;
   item_type         head;
   logic             push;
   logic             pop;

   assign csr_ready = 1'b1;

   tccw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_char_code (req_char_code),
      .req_cell_row  (req_cell_row),
      .req_cell_col  (req_cell_col),
      .q_status      (q_status),
      .push          (push),
      .item          (push_item)
   );

   tccw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   tccw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .head               (head),
      .pop                (pop),
      .csr_valid          (csr_valid),
      .csr_text_attribute (csr_text_attribute),
      .rsp_strobe         (rsp_strobe),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_cursor_col     (rsp_cursor_col),
      .rsp_read_entry     (rsp_read_entry),
      .rsp_scrolled       (rsp_scrolled)
   );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
module tb;
   import tccw_pkg::*;

   localparam int COLUMNS = COLUMNS_DEFAULT;
   localparam int ROWS    = ROWS_DEFAULT;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 322;
   localparam longint CYCLE_LIMIT = 10_000_000;
   localparam int TAIL_CYCLES = COLUMNS + 16;

   typedef struct packed {
      logic [ROW_PORT_W-1:0] row;
      logic [COL_PORT_W-1:0] col;
      logic [ENTRY_W-1:0]    entry;
      logic                  scrolled;
   } console_reply_type;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [CHAR_W-1:0]     ch;
      logic [ROW_PORT_W-1:0] row;
      logic [COL_PORT_W-1:0] col;
      logic [7:0]            reps;
      logic                  typed;
      console_reply_type     reply;
   } script_step_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [CMD_W-1:0]      req_command;
   logic [CHAR_W-1:0]     req_char_code;
   logic [ROW_PORT_W-1:0] req_cell_row;
   logic [COL_PORT_W-1:0] req_cell_col;
   logic                  rsp_strobe;
   logic [ROW_PORT_W-1:0] rsp_cursor_row;
   logic [COL_PORT_W-1:0] rsp_cursor_col;
   logic [ENTRY_W-1:0]    rsp_read_entry;
   logic                  rsp_scrolled;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [ATTR_W-1:0]     csr_text_attribute;

   text_console_cell_writer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_char_code      (req_char_code),
      .req_cell_row       (req_cell_row),
      .req_cell_col       (req_cell_col),
      .rsp_strobe         (rsp_strobe),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_cursor_col     (rsp_cursor_col),
      .rsp_read_entry     (rsp_read_entry),
      .rsp_scrolled       (rsp_scrolled),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_text_attribute (csr_text_attribute)
   );

   console_reply_type console_replies[$];
   script_step_type   script[$];
   logic [ENTRY_W-1:0] screen [ROWS][COLUMNS];
   bit                filled [ROWS][COLUMNS];
   int                cur_row;
   int                cur_col;
   logic [ATTR_W-1:0] attr_shadow;
   int                mismatch_count = 0;
   longint            cycle_count = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic line_feed();
      cur_col = 0;
      cur_row++;
      if (cur_row < ROWS)
         return 1'b0;
      for (int r = 0; r < ROWS - 1; r++)
         for (int c = 0; c < COLUMNS; c++) begin
            screen[r][c] = screen[r + 1][c];
            filled[r][c] = filled[r + 1][c];
         end
      for (int c = 0; c < COLUMNS; c++) begin
         screen[ROWS - 1][c] = {attr_shadow, CH_SPACE};
         filled[ROWS - 1][c] = 1'b1;
      end
      cur_row = ROWS - 1;
      return 1'b1;
   endfunction

   function automatic console_reply_type advance_console(input logic [CMD_W-1:0] cmd,
                                                         input logic [CHAR_W-1:0] ch,
                                                         input logic [ROW_PORT_W-1:0] row,
                                                         input logic [COL_PORT_W-1:0] col);
      console_reply_type reply;
      reply = '0;
      case (cmd)
         CMD_PUT: begin
            if (ch == CH_NEWLINE) begin
               reply.scrolled = line_feed();
            end else if (ch == CH_TAB) begin
               cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
               if (cur_col >= COLUMNS)
                  reply.scrolled = line_feed();
            end else begin
               screen[cur_row][cur_col] = {attr_shadow, ch};
               filled[cur_row][cur_col] = 1'b1;
               cur_col++;
               if (cur_col >= COLUMNS)
                  reply.scrolled = line_feed();
            end
         end
         CMD_CLEAR: begin
            for (int r = 0; r < ROWS; r++)
               for (int c = 0; c < COLUMNS; c++) begin
                  screen[r][c] = {attr_shadow, CH_SPACE};
                  filled[r][c] = 1'b1;
               end
            cur_row = 0;
            cur_col = 0;
         end
         CMD_READ: begin
            if (row < ROWS && col < COLUMNS)
               reply.entry = screen[row][col];
         end
         default: ;
      endcase
      reply.row = ROW_PORT_W'(cur_row);
      reply.col = COL_PORT_W'(cur_col);
      return reply;
   endfunction

   task automatic report_field(input string field, input logic [ENTRY_W-1:0] want,
                               input logic [ENTRY_W-1:0] got);
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      console_reply_type want;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (console_replies.size() == 0) begin
            $display("%0t: result with nothing outstanding, row %h col %h entry %h",
                     $time, rsp_cursor_row, rsp_cursor_col, rsp_read_entry);
            mismatch_count++;
         end else begin
            want = console_replies.pop_front();
            if (rsp_cursor_row !== want.row)
               report_field("cursor_row", ENTRY_W'(want.row), ENTRY_W'(rsp_cursor_row));
            if (rsp_cursor_col !== want.col)
               report_field("cursor_col", ENTRY_W'(want.col), ENTRY_W'(rsp_cursor_col));
            if (rsp_read_entry !== want.entry)
               report_field("read_entry", want.entry, rsp_read_entry);
            if (rsp_scrolled !== want.scrolled)
               report_field("scrolled", ENTRY_W'(want.scrolled), ENTRY_W'(rsp_scrolled));
         end
      end
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55)
         return 0;
      if (p < 85)
         return $urandom_range(1, 3);
      if (p < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                               input logic [ROW_PORT_W-1:0] row,
                               input logic [COL_PORT_W-1:0] col,
                               input logic typed, input console_reply_type typed_reply);
      console_reply_type reply;
      @(negedge clock);
      start         <= 1'b1;
      req_command   <= cmd;
      req_char_code <= ch;
      req_cell_row  <= row;
      req_cell_col  <= col;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      reply = advance_console(cmd, ch, row, col);
      console_replies.push_back(typed ? typed_reply : reply);
   endtask

   task automatic wait_drained();
      while (console_replies.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      hold_off(1);
      wait_drained();
      @(negedge clock);
      csr_valid          <= 1'b1;
      csr_text_attribute <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      attr_shadow = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_step(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_PORT_W-1:0] row,
                           input logic [COL_PORT_W-1:0] col, input int reps,
                           input int typed, input logic [ROW_PORT_W-1:0] exp_row,
                           input logic [COL_PORT_W-1:0] exp_col,
                           input logic [ENTRY_W-1:0] exp_entry, input logic exp_scrolled);
      script_step_type s;
      s.cmd            = cmd;
      s.ch             = ch;
      s.row            = row;
      s.col            = col;
      s.reps           = 8'(reps);
      s.typed          = (typed != 0);
      s.reply.row      = exp_row;
      s.reply.col      = exp_col;
      s.reply.entry    = exp_entry;
      s.reply.scrolled = exp_scrolled;
      script.push_back(s);
   endtask

   task automatic random_command();
      int                    pick;
      logic [CMD_W-1:0]      cmd;
      logic [CHAR_W-1:0]     ch;
      logic [ROW_PORT_W-1:0] row;
      logic [COL_PORT_W-1:0] col;
      pick = $urandom_range(0, 999);
      ch   = CHAR_W'($urandom_range(0, 255));
      row  = ROW_PORT_W'($urandom_range(0, 31));
      col  = COL_PORT_W'($urandom_range(0, 127));
      cmd  = CMD_PUT;
      if (pick < 8) begin
         cmd = CMD_CLEAR;
      end else if (pick < 20) begin
         cmd = CMD_UNUSED;
      end else if (pick < 200) begin
         cmd = CMD_READ;
         if (pick < 150) begin
            row = ROW_PORT_W'($urandom_range(0, ROWS - 1));
            col = COL_PORT_W'($urandom_range(0, COLUMNS - 1));
         end
         // steer away from cells never written
         if (row < ROWS && col < COLUMNS && !filled[row][col])
            col = COL_PORT_W'($urandom_range(COLUMNS, 127));
      end else if (pick < 300) begin
         ch = CH_NEWLINE;
      end else if (pick < 400) begin
         ch = CH_TAB;
      end
      send_command(cmd, ch, row, col, 1'b0, '0);
   endtask

   initial begin
      bit steady;
      reset              = 1'b1;
      start              = 1'b0;
      req_command        = CMD_PUT;
      req_char_code      = '0;
      req_cell_row       = '0;
      req_cell_col       = '0;
      csr_valid          = 1'b0;
      csr_text_attribute = '0;
      cur_row            = 0;
      cur_col            = 0;
      attr_shadow        = ATTR_RESET;
      steady             = 1'b0;
      for (int r = 0; r < ROWS; r++)
         for (int c = 0; c < COLUMNS; c++) begin
            screen[r][c] = '0;
            filled[r][c] = 1'b0;
         end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_step(CMD_UNUSED, 8'hFF, 5'd31, 7'd127, 1, 1, 5'd0, 7'd0, 16'h0000, 1'b0);
      add_step(CMD_READ, 8'h00, 5'd31, 7'd127, 1, 1, 5'd0, 7'd0, 16'h0000, 1'b0);
      add_step(CMD_READ, 8'h00, 5'd24, 7'd80, 1, 1, 5'd0, 7'd0, 16'h0000, 1'b0);
      add_step(CMD_READ, 8'h00, 5'd25, 7'd0, 1, 1, 5'd0, 7'd0, 16'h0000, 1'b0);
      add_step(CMD_PUT, 8'h41, 5'd0, 7'd0, 1, 1, 5'd0, 7'd1, 16'h0000, 1'b0);
      add_step(CMD_READ, 8'h00, 5'd0, 7'd0, 1, 1, 5'd0, 7'd1, 16'h0741, 1'b0);
      add_step(CMD_PUT, 8'h00, 5'd31, 7'd127, 1, 0, '0, '0, '0, '0);
      add_step(CMD_PUT, 8'hFF, 5'd0, 7'd0, 1, 0, '0, '0, '0, '0);
      add_step(CMD_PUT, CH_TAB, 5'd0, 7'd0, 1, 1, 5'd0, 7'd4, 16'h0000, 1'b0);
      add_step(CMD_PUT, CH_TAB, 5'd31, 7'd127, 1, 0, '0, '0, '0, '0);
      add_step(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0, 1, 1, 5'd1, 7'd0, 16'h0000, 1'b0);
      add_step(CMD_READ, 8'h00, 5'd0, 7'd2, 1, 0, '0, '0, '0, '0);
      add_step(CMD_READ, 8'h00, 5'd0, 7'd1, 1, 0, '0, '0, '0, '0);
      add_step(CMD_CLEAR, 8'hFF, 5'd31, 7'd127, 1, 1, 5'd0, 7'd0, 16'h0000, 1'b0);
      add_step(CMD_READ, 8'h00, 5'd24, 7'd79, 1, 1, 5'd0, 7'd0, 16'h0720, 1'b0);
      add_step(CMD_READ, 8'h00, 5'd0, 7'd0, 1, 1, 5'd0, 7'd0, 16'h0720, 1'b0);
      add_step(CMD_PUT, 8'h7E, 5'd0, 7'd0, 1, 0, '0, '0, '0, '0);
      add_step(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0, 24, 0, '0, '0, '0, '0);
      add_step(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0, 1, 1, 5'd24, 7'd0, 16'h0000, 1'b1);
      add_step(CMD_READ, 8'h00, 5'd24, 7'd0, 1, 1, 5'd24, 7'd0, 16'h0720, 1'b0);
      add_step(CMD_READ, 8'h00, 5'd22, 7'd0, 1, 0, '0, '0, '0, '0);
      add_step(CMD_PUT, CH_TAB, 5'd0, 7'd0, 19, 0, '0, '0, '0, '0);
      add_step(CMD_PUT, CH_TAB, 5'd0, 7'd0, 1, 1, 5'd24, 7'd0, 16'h0000, 1'b1);
      add_step(CMD_READ, 8'h00, 5'd23, 7'd79, 1, 0, '0, '0, '0, '0);

      foreach (script[i])
         repeat (script[i].reps) begin
            hold_off(pick_gap());
            send_command(script[i].cmd, script[i].ch, script[i].row, script[i].col,
                         script[i].typed, script[i].reply);
         end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_attribute(8'hFF);
            1: write_attribute(8'h00);
            default: write_attribute(ATTR_W'($urandom_range(0, 255)));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 48 == 0)
               steady = ($urandom_range(0, 2) == 0);
            hold_off(steady ? 0 : pick_gap());
            random_command();
         end
      end

      hold_off(1);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && console_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
